>>> rtl/core/wpt_pkg.sv
// ----------------------------------------------------------------------------
// Wait profile table package
// Widths, status and command codes, and record types shared by the block,
// its channel interfaces and its storage.
// ----------------------------------------------------------------------------
package wpt_pkg;

  localparam int ENTRIES_DEFAULT = 64;

  localparam int KEY_W    = 48;
  localparam int TIME_W   = 48;
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 64;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 6;
  localparam int USED_W   = 7;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 3'd5;

  // Per-entry statistics, held in one memory word.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  max_wait;
    logic [TOTAL_W-1:0] total_wait;
  } stats_t;

  // Site identity, held in one memory word; the kind survives a clear.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } site_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [COUNT_W-1:0]  entry_count;
    logic [TIME_W-1:0]   entry_max_wait;
    logic [TOTAL_W-1:0]  entry_total_wait;
    logic [KIND_W-1:0]   entry_kind;
    logic [USED_W-1:0]   used_entries;
  } result_t;

endpackage

>>> rtl/core/wpt_in_if.sv
// ----------------------------------------------------------------------------
// Wait profile table input channel
// Valid/ready channel carrying one record or clear word.
// ----------------------------------------------------------------------------
interface wpt_in_if import wpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic [KIND_W-1:0] wait_kind;

  modport source (
    output valid, command, key, start_time, end_time, wait_kind,
    input  ready
  );
  modport sink (
    input  valid, command, key, start_time, end_time, wait_kind,
    output ready
  );
endinterface

>>> rtl/core/wpt_out_if.sv
// ----------------------------------------------------------------------------
// Wait profile table result channel
// Valid/ready channel carrying one result word per input word.
// ----------------------------------------------------------------------------
interface wpt_out_if import wpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  entry_index;
  logic [COUNT_W-1:0]  entry_count;
  logic [TIME_W-1:0]   entry_max_wait;
  logic [TOTAL_W-1:0]  entry_total_wait;
  logic [KIND_W-1:0]   entry_kind;
  logic [USED_W-1:0]   used_entries;

  modport source (
    output valid, status, entry_index, entry_count, entry_max_wait,
           entry_total_wait, entry_kind, used_entries,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, entry_count, entry_max_wait,
           entry_total_wait, entry_kind, used_entries,
    output ready
  );
endinterface

>>> rtl/core/wpt_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/wait_profile_table_unit.sv
// ----------------------------------------------------------------------------
// Wait profile table
// Per-site table of wait counts, maximum waits and total waits.
// ----------------------------------------------------------------------------
// Entries are allocated in order and never freed, so the allocated entries
// always form the range from zero to the used count; the table needs no
// clearing after reset. A record word searches that range one entry per
// cycle through the read port of the key memory; a hit updates that entry,
// a miss allocates the next entry unless the table is full, and a disabled
// or zero-key record skips the search. A clear word writes zero statistics
// into every allocated entry, one per cycle. One word is worked on at a
// time; the result waits in an output register while the next word is
// taken, and a word that finishes while that register is still full waits
// until the result is taken.
module wait_profile_table_unit import wpt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  logic   cfg_wdata,
  wpt_in_if.sink item,
  wpt_out_if.source result
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state;
  logic              enable;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;

  logic [KEY_W-1:0]  item_key;
  logic [KIND_W-1:0] item_kind;
  logic [TIME_W-1:0] item_wait;

  result_t           res;
  result_t           out_q;
  logic              out_valid;

  logic              accept;
  logic              issue;
  logic              hit;
  logic              miss;
  logic              full;
  logic              out_free;

  site_t             site_wdata;
  site_t             site_rdata;
  logic              site_we;
  stats_t            stats_wdata;
  stats_t            stats_rdata;
  stats_t            stats_hit;
  logic              stats_we;
  logic [IDX_W-1:0]  stats_waddr;

  assign accept   = item.valid && item.ready;
  assign item.ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || result.ready;
  assign full     = (used == CNT_W'(ENTRIES));

  // Reads go out one entry ahead of the compare, so the key read at one
  // index is checked in the cycle after it was addressed.
  assign issue = (state == S_SCAN) && (scan_idx != used) && !hit;
  assign hit   = (state == S_SCAN) && cmp_vld && (site_rdata.key == item_key);
  assign miss  = (state == S_SCAN) && !cmp_vld && (scan_idx == used);

  always_comb begin
    stats_hit.count = stats_rdata.count + COUNT_W'(1);
    stats_hit.max_wait = (item_wait > stats_rdata.max_wait) ? item_wait
                                                            : stats_rdata.max_wait;
    stats_hit.total_wait = stats_rdata.total_wait + TOTAL_W'(item_wait);
  end

  always_comb begin
    site_we          = (state == S_ALLOC);
    site_wdata.kind  = item_kind;
    site_wdata.key   = item_key;
    stats_we         = 1'b0;
    stats_waddr      = scan_idx[IDX_W-1:0];
    stats_wdata      = '0;
    if (hit) begin
      stats_we    = 1'b1;
      stats_waddr = cmp_idx;
      stats_wdata = stats_hit;
    end else if (state == S_ALLOC) begin
      stats_we               = 1'b1;
      stats_waddr            = used[IDX_W-1:0];
      stats_wdata.count      = COUNT_W'(1);
      stats_wdata.max_wait   = item_wait;
      stats_wdata.total_wait = TOTAL_W'(item_wait);
    end else if ((state == S_CLEAR) && (scan_idx != used)) begin
      stats_we = 1'b1;
    end
  end

  wpt_ram #(
    .WIDTH ($bits(site_t)),
    .DEPTH (ENTRIES)
  ) u_site_ram (
    .clk   (clk),
    .we    (site_we),
    .waddr (used[IDX_W-1:0]),
    .wdata (site_wdata),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (site_rdata)
  );

  wpt_ram #(
    .WIDTH ($bits(stats_t)),
    .DEPTH (ENTRIES)
  ) u_stats_ram (
    .clk   (clk),
    .we    (stats_we),
    .waddr (stats_waddr),
    .wdata (stats_wdata),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (stats_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_we) begin
      enable <= cfg_wdata;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      scan_idx  <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_vld <= issue;
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          scan_idx <= '0;
          if (accept) begin
            if (item.command == CMD_CLEAR) begin
              state <= S_CLEAR;
            end else if (!enable || (item.key == '0)) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (hit) begin
            state <= S_FIN;
          end else if (miss) begin
            state <= full ? S_FIN : S_ALLOC;
          end
        end
        S_ALLOC: begin
          used  <= used + CNT_W'(1);
          state <= S_FIN;
        end
        S_CLEAR: begin
          if (scan_idx == used) begin
            state <= S_FIN;
          end else begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item fields and the staged result.
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx[IDX_W-1:0];
    if (accept) begin
      item_key  <= item.key;
      item_kind <= item.wait_kind;
      item_wait <= item.end_time - item.start_time;
      res       <= '0;
      if (item.command == CMD_CLEAR) begin
        res.status <= ST_CLEARED;
      end else if (!enable) begin
        res.status <= ST_DISABLED;
      end else if (item.key == '0) begin
        res.status <= ST_ZERO_KEY;
      end
    end
    if (hit) begin
      res.status           <= ST_HIT;
      res.entry_index      <= INDEX_W'(cmp_idx);
      res.entry_count      <= stats_hit.count;
      res.entry_max_wait   <= stats_hit.max_wait;
      res.entry_total_wait <= stats_hit.total_wait;
      res.entry_kind       <= site_rdata.kind;
    end else if (miss && full) begin
      res.status <= ST_FULL;
    end
    if (state == S_ALLOC) begin
      res.status           <= ST_ALLOC;
      res.entry_index      <= INDEX_W'(used);
      res.entry_count      <= COUNT_W'(1);
      res.entry_max_wait   <= item_wait;
      res.entry_total_wait <= TOTAL_W'(item_wait);
      res.entry_kind       <= item_kind;
    end
    if ((state == S_FIN) && out_free) begin
      out_q              <= res;
      out_q.used_entries <= USED_W'(used);
    end
  end

  assign result.valid            = out_valid;
  assign result.status           = out_q.status;
  assign result.entry_index      = out_q.entry_index;
  assign result.entry_count      = out_q.entry_count;
  assign result.entry_max_wait   = out_q.entry_max_wait;
  assign result.entry_total_wait = out_q.entry_total_wait;
  assign result.entry_kind       = out_q.entry_kind;
  assign result.used_entries     = out_q.used_entries;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wait profile table testbench
// Sends record and clear words through the input channel and predicts every
// result word from a private copy of the table. Directed words cover the
// timestamp extremes, the wrapping wait, the zero key, the disabled state
// and a clear. Random traffic then reuses sites, fills the table and runs it
// full, under varying stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import wpt_pkg::*;

  localparam int TABLE_DEPTH  = ENTRIES_DEFAULT;
  localparam int POOL_SIZE    = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int QUIET_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 100;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  wpt_in_if  in_ch ();
  wpt_out_if out_ch ();

  wait_profile_table_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (in_ch),
    .result    (out_ch)
  );

  // Private copy of the table.
  bit [KEY_W-1:0]   tab_keys   [TABLE_DEPTH];
  bit [COUNT_W-1:0] tab_counts [TABLE_DEPTH];
  bit [TIME_W-1:0]  tab_max    [TABLE_DEPTH];
  bit [TOTAL_W-1:0] tab_totals [TABLE_DEPTH];
  bit [KIND_W-1:0]  tab_kinds  [TABLE_DEPTH];
  int unsigned      used_count;
  bit               prof_enable;

  result_t          profile_q [$];
  logic [KEY_W-1:0] site_pool [POOL_SIZE];

  int src_idle_pct;
  int sink_idle_pct;
  int mismatches;
  int quiet_cycles;
  int hold_asked;
  int hold_taken;
  int hold_left;

  always #10 clk = ~clk;

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  // Applies one word to the private table and returns the result it gives.
  function automatic result_t predict_profile(input logic cmd,
                                              input logic [KEY_W-1:0] key,
                                              input logic [TIME_W-1:0] t_start,
                                              input logic [TIME_W-1:0] t_end,
                                              input logic [KIND_W-1:0] kind);
    result_t          r;
    logic [TIME_W-1:0] wt;
    int               slot;
    r = '0;
    slot = -1;
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        tab_counts[i] = '0;
        tab_max[i]    = '0;
        tab_totals[i] = '0;
      end
      r.status = ST_CLEARED;
    end else if (!prof_enable) begin
      r.status = ST_DISABLED;
    end else if (key == '0) begin
      r.status = ST_ZERO_KEY;
    end else begin
      wt = t_end - t_start;
      for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
        if (tab_keys[i] == key) slot = i;
      if (slot >= 0) begin
        tab_counts[slot] = tab_counts[slot] + 1;
        if (wt > tab_max[slot]) tab_max[slot] = wt;
        tab_totals[slot] = tab_totals[slot] + wt;
        r.status = ST_HIT;
      end else if (used_count < TABLE_DEPTH) begin
        // Entries are never freed, so the first empty one follows the used ones.
        slot = int'(used_count);
        tab_keys[slot]   = key;
        tab_counts[slot] = 1;
        tab_kinds[slot]  = kind;
        tab_max[slot]    = wt;
        tab_totals[slot] = {16'h0, wt};
        used_count++;
        r.status = ST_ALLOC;
      end else begin
        r.status = ST_FULL;
      end
      if (slot >= 0) begin
        r.entry_index      = INDEX_W'(slot);
        r.entry_count      = tab_counts[slot];
        r.entry_max_wait   = tab_max[slot];
        r.entry_total_wait = tab_totals[slot];
        r.entry_kind       = tab_kinds[slot];
      end
    end
    r.used_entries = USED_W'(used_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Result words are compared with the oldest prediction as they are taken.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (profile_q.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, status %0d", $time,
                 out_ch.status);
      end else begin
        want = profile_q.pop_front();
        check_field("status", 64'(want.status), 64'(out_ch.status));
        check_field("entry_index", 64'(want.entry_index), 64'(out_ch.entry_index));
        check_field("entry_count", 64'(want.entry_count), 64'(out_ch.entry_count));
        check_field("entry_max_wait", 64'(want.entry_max_wait),
                    64'(out_ch.entry_max_wait));
        check_field("entry_total_wait", want.entry_total_wait,
                    out_ch.entry_total_wait);
        check_field("entry_kind", 64'(want.entry_kind), 64'(out_ch.entry_kind));
        check_field("used_entries", 64'(want.used_entries),
                    64'(out_ch.used_entries));
      end
    end
  end

  // Result side readiness, with an occasional long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_asked != hold_taken) begin
      hold_taken   <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [TIME_W-1:0] t_start,
                           input logic [TIME_W-1:0] t_end,
                           input logic [KIND_W-1:0] kind);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.key        <= key;
    in_ch.start_time <= t_start;
    in_ch.end_time   <= t_end;
    in_ch.wait_kind  <= kind;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    profile_q.push_back(predict_profile(cmd, key, t_start, t_end, kind));
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic drain_results(input int extra_cycles);
    in_ch.valid <= 1'b0;
    wait (profile_q.size() == 0);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    drain_results(8);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    prof_enable  = value;
  endtask

  task automatic request_hold();
    hold_asked++;
  endtask

  task automatic send_record(input logic [KEY_W-1:0] key);
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    t_start = rand48();
    case ($urandom_range(3))
      0: t_end = t_start + $urandom_range(1000);
      1: t_end = rand48();
      2: t_end = t_start - $urandom_range(1, 15);
      default: t_end = t_start + (rand48() >> $urandom_range(8, 40));
    endcase
    send_word(CMD_RECORD, key, t_start, t_end, KIND_W'($urandom_range(3)));
  endtask

  task automatic send_mixed(input int fresh_pct, input int clear_pct);
    int               r;
    logic [KEY_W-1:0] key;
    r = $urandom_range(99);
    if (r < clear_pct) begin
      send_word(CMD_CLEAR, rand48(), rand48(), rand48(), KIND_W'($urandom_range(3)));
    end else begin
      r = $urandom_range(99);
      if (r < 5)
        key = '0;
      else if (r < 5 + fresh_pct)
        key = rand48();
      else if (used_count > 0 && r[0])
        key = tab_keys[$urandom_range(used_count - 1)];
      else
        key = site_pool[$urandom_range(POOL_SIZE - 1)];
      send_record(key);
    end
  endtask

  task automatic test_reset_state();
    // Enable is low after reset: records are refused even with a zero key.
    send_word(CMD_RECORD, '1, '0, '1, 2'd3);
    send_word(CMD_RECORD, '0, '0, '0, 2'd0);
    send_word(CMD_CLEAR, '0, '0, '0, 2'd0);
  endtask

  task automatic test_directed_records();
    write_enable(1'b1);
    send_word(CMD_RECORD, '0, 48'd10, 48'd20, 2'd1);
    send_word(CMD_RECORD, '1, '0, '1, 2'd3);
    // End before start wraps round to a wait of one.
    send_word(CMD_RECORD, '1, '1, '0, 2'd0);
    send_word(CMD_RECORD, 48'd1, 48'd5, 48'd5, 2'd1);
    send_word(CMD_RECORD, 48'd1, 48'd100, 48'd40, 2'd2);
    send_word(CMD_RECORD, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
              48'h8000_0000_0000, 2'd2);
    send_word(CMD_RECORD, 48'h5555_5555_5555, 48'h5555_5555_5555,
              48'hAAAA_AAAA_AAAA, 2'd0);
    send_word(CMD_RECORD, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA,
              48'h5555_5555_5555, 2'd3);
    send_word(CMD_RECORD, 48'h8000_0000_0000, '0, '0, 2'd1);
    send_word(CMD_CLEAR, '1, '1, '1, 2'd3);
    // After a clear the keys and kinds stay; the kind of a hit is not taken.
    send_word(CMD_RECORD, '1, 48'd3, 48'd9, 2'd1);
    send_word(CMD_RECORD, 48'd1, '0, 48'd7, 2'd3);
    write_enable(1'b0);
    send_word(CMD_RECORD, 48'd1, '0, 48'd7, 2'd3);
    send_word(CMD_CLEAR, '0, '0, '0, 2'd0);
    write_enable(1'b1);
    send_word(CMD_RECORD, 48'd1, 48'd2, 48'd3, 2'd0);
  endtask

  task automatic test_site_reuse();
    site_pool[0] = '1;
    site_pool[1] = 48'd1;
    site_pool[2] = 48'h8000_0000_0000;
    site_pool[3] = 48'h5555_5555_5555;
    for (int i = 4; i < POOL_SIZE; i++)
      do site_pool[i] = rand48(); while (site_pool[i] == '0);
    src_idle_pct  = 12;
    sink_idle_pct = 66;
    for (int i = 0; i < 250; i++) begin
      // The result side stops for a long while as the sender keeps offering.
      if (i == 120) request_hold();
      send_mixed(4, 3);
    end
  endtask

  task automatic test_disabled_traffic();
    write_enable(1'b0);
    for (int i = 0; i < 20; i++) send_mixed(20, 10);
    write_enable(1'b1);
  endtask

  task automatic test_table_fill();
    src_idle_pct  = 66;
    sink_idle_pct = 12;
    for (int i = 0; i < 250; i++) send_mixed(40, 2);
  endtask

  task automatic test_full_table();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (int i = 0; i < 250; i++) send_mixed(20, 5);
  endtask

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_RECORD;
    in_ch.key        = '0;
    in_ch.start_time = '0;
    in_ch.end_time   = '0;
    in_ch.wait_kind  = '0;
    used_count       = 0;
    prof_enable      = 1'b0;
    hold_asked       = 0;
    src_idle_pct     = 12;
    sink_idle_pct    = 66;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_records();
    test_site_reuse();
    test_disabled_traffic();
    test_table_fill();
    test_full_table();
    drain_results(DRAIN_CYCLES);
    if (mismatches == 0 && profile_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
